// ----- design/teq_pkg.sv -----
`default_nettype none

package teq_pkg;

    localparam int QUEUE_DEPTH_DEF = 64;
    localparam int TIME_BITS_DEF   = 32;
    localparam int BLOCK_BITS_DEF  = 16;

    // most events released by one block request
    localparam int MAX_RESULTS = 64;

    localparam int STATUS_BITS = 8;
    localparam int DATA_BITS   = 7;
    localparam int BYTE_BITS   = STATUS_BITS + 2 * DATA_BITS;

    localparam logic CMD_APPEND = 1'b0;
    localparam logic CMD_BLOCK  = 1'b1;

endpackage

`default_nettype wire

// ----- design/teq_req_if.sv -----
`default_nettype none

interface teq_req_if
    import teq_pkg::*;
#(
    parameter int TIME_BITS  = TIME_BITS_DEF,
    parameter int BLOCK_BITS = BLOCK_BITS_DEF
);
    logic                   valid;
    logic                   ready;
    logic                   command;
    logic [TIME_BITS-1:0]   event_time;
    logic [STATUS_BITS-1:0] event_status;
    logic [DATA_BITS-1:0]   event_first_data;
    logic [DATA_BITS-1:0]   event_second_data;
    logic [TIME_BITS-1:0]   block_start;
    logic [BLOCK_BITS-1:0]  block_size;

    modport source (
        output valid, command, event_time, event_status, event_first_data,
               event_second_data, block_start, block_size,
        input  ready
    );

    modport sink (
        input  valid, command, event_time, event_status, event_first_data,
               event_second_data, block_start, block_size,
        output ready
    );
endinterface

`default_nettype wire

// ----- design/teq_rsp_if.sv -----
`default_nettype none

interface teq_rsp_if
    import teq_pkg::*;
#(
    parameter int BLOCK_BITS = BLOCK_BITS_DEF
);
    logic                   valid;
    logic                   ready;
    logic                   released;
    logic [STATUS_BITS-1:0] out_status;
    logic [DATA_BITS-1:0]   out_first_data;
    logic [DATA_BITS-1:0]   out_second_data;
    logic [BLOCK_BITS-1:0]  delta_frames;
    logic                   last;
    logic                   more_remaining;
    logic                   order_error;
    logic                   append_dropped;
    logic [31:0]            released_total;

    modport source (
        output valid, released, out_status, out_first_data, out_second_data,
               delta_frames, last, more_remaining, order_error, append_dropped,
               released_total,
        input  ready
    );

    modport sink (
        input  valid, released, out_status, out_first_data, out_second_data,
               delta_frames, last, more_remaining, order_error, append_dropped,
               released_total,
        output ready
    );
endinterface

`default_nettype wire

// ----- design/timestamped_event_release_queue_top.sv -----
// timestamp ordered event queue
// i_req carries one request: command 0 appends one event (time plus three
// midi bytes) at the tail, command 1 releases one block [block_start,
// block_start + block_size), the end saturating at the largest timestamp.
// o_rsp returns one result per released event, in queue order, with the
// offset from block_start; a request that releases nothing, and every
// append, gives a single result with released low. last marks the final
// result of a request, which also carries more_remaining, order_error
// (events older than the block start were dropped) and append_dropped.
// steps, from one accepted request to the next: an append passes through the
// finish state; a block request passes a read and a check state per entry
// examined, one more read state when the walk empties the queue or hits the
// release limit, then the finish state; each entry is one registered read of
// the event memory and one pass through the shared subtract and compare unit.
// one request is worked on at a time; i_req.ready is low until its final
// result sits in the output register.
// a released result is held one step until the walk knows whether it is
// the last; when o_rsp.ready is low the walk waits with it.
// reset empties the queue and clears the release count; no clearing pass.
`default_nettype none

module timestamped_event_release_queue_top
    import teq_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF,
    parameter int TIME_BITS   = TIME_BITS_DEF,
    parameter int BLOCK_BITS  = BLOCK_BITS_DEF
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    teq_req_if.sink    i_req,
    teq_rsp_if.source  o_rsp
);

    localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CW = $clog2(QUEUE_DEPTH + 1);
    localparam int NW = $clog2(MAX_RESULTS + 1);
    localparam int WW = TIME_BITS + BLOCK_BITS;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_CHECK,
        ST_FINISH
    } t_state;

    t_state r_state, n_state;

    logic [TIME_BITS-1:0] r_times [QUEUE_DEPTH];
    logic [BYTE_BITS-1:0] r_bytes [QUEUE_DEPTH];
    logic [TIME_BITS-1:0] r_rd_time;
    logic [BYTE_BITS-1:0] r_rd_bytes;

    logic [AW-1:0]         r_head, n_head, r_tail, n_tail;
    logic [CW-1:0]         r_count, n_count;
    logic [31:0]           r_total, n_total;
    logic [NW-1:0]         r_nrel, n_nrel;
    logic [TIME_BITS-1:0]  r_start, n_start;
    logic [BLOCK_BITS-1:0] r_span, n_span;
    logic                  r_oerr, n_oerr;
    logic                  r_adrop, n_adrop;
    // held release, waiting to learn whether it is the last one
    logic                  r_pv, n_pv;
    logic [BYTE_BITS-1:0]  r_pbytes, n_pbytes;
    logic [BLOCK_BITS-1:0] r_pdelta, n_pdelta;

    logic                  r_out_valid, n_out_valid;
    logic                  r_out_released, n_out_released;
    logic [BYTE_BITS-1:0]  r_out_bytes, n_out_bytes;
    logic [BLOCK_BITS-1:0] r_out_delta, n_out_delta;
    logic                  r_out_last, n_out_last;
    logic                  r_out_more, n_out_more;
    logic                  r_out_oerr, n_out_oerr;
    logic                  r_out_adrop, n_out_adrop;
    logic [31:0]           r_out_total, n_out_total;

    logic                  in_fire, out_free, full, do_write;
    logic [TIME_BITS:0]    diff;
    logic [WW-1:0]         diff_ext, room_ext, size_ext;
    logic                  stale, in_range;
    logic [AW-1:0]         head_next, tail_next;

    assign in_fire   = i_req.valid && (r_state == ST_IDLE);
    assign out_free  = !r_out_valid || o_rsp.ready;
    assign full      = (r_count == CW'(QUEUE_DEPTH));
    assign do_write  = in_fire && (i_req.command == CMD_APPEND) && !full;
    assign head_next = (r_head == AW'(QUEUE_DEPTH - 1)) ? '0 : r_head + 1'b1;
    assign tail_next = (r_tail == AW'(QUEUE_DEPTH - 1)) ? '0 : r_tail + 1'b1;

    // shared subtract and compare: offset from block start, borrow means stale
    assign diff     = {1'b0, r_rd_time} - {1'b0, r_start};
    assign stale    = diff[TIME_BITS];
    assign diff_ext = WW'(diff[TIME_BITS-1:0]);
    assign in_range = !stale && (diff_ext < WW'(r_span));

    // room left before the largest timestamp, for the saturated block end
    assign room_ext = {{BLOCK_BITS{1'b0}}, ~i_req.block_start};
    assign size_ext = WW'(i_req.block_size);

    always_comb begin
        n_state        = r_state;
        n_head         = r_head;
        n_tail         = r_tail;
        n_count        = r_count;
        n_total        = r_total;
        n_nrel         = r_nrel;
        n_start        = r_start;
        n_span         = r_span;
        n_oerr         = r_oerr;
        n_adrop        = r_adrop;
        n_pv           = r_pv;
        n_pbytes       = r_pbytes;
        n_pdelta       = r_pdelta;
        n_out_valid    = r_out_valid && !o_rsp.ready;
        n_out_released = r_out_released;
        n_out_bytes    = r_out_bytes;
        n_out_delta    = r_out_delta;
        n_out_last     = r_out_last;
        n_out_more     = r_out_more;
        n_out_oerr     = r_out_oerr;
        n_out_adrop    = r_out_adrop;
        n_out_total    = r_out_total;

        case (r_state)
            ST_IDLE: begin
                if (in_fire) begin
                    n_oerr = 1'b0;
                    n_pv   = 1'b0;
                    n_nrel = '0;
                    if (i_req.command == CMD_APPEND) begin
                        n_adrop = full;
                        if (!full) begin
                            n_tail  = tail_next;
                            n_count = r_count + 1'b1;
                        end
                        n_state = ST_FINISH;
                    end else begin
                        n_adrop = 1'b0;
                        n_start = i_req.block_start;
                        n_span  = (room_ext < size_ext) ?
                                  BLOCK_BITS'(room_ext) : i_req.block_size;
                        n_state = ST_READ;
                    end
                end
            end
            ST_READ: begin
                if (r_count == '0 || r_nrel == NW'(MAX_RESULTS)) begin
                    n_state = ST_FINISH;
                end else begin
                    n_state = ST_CHECK;
                end
            end
            ST_CHECK: begin
                if (stale) begin
                    n_oerr  = 1'b1;
                    n_head  = head_next;
                    n_count = r_count - 1'b1;
                    n_state = ST_READ;
                end else if (in_range) begin
                    if (!r_pv || out_free) begin
                        if (r_pv) begin
                            n_out_valid    = 1'b1;
                            n_out_released = 1'b1;
                            n_out_bytes    = r_pbytes;
                            n_out_delta    = r_pdelta;
                            n_out_last     = 1'b0;
                            n_out_more     = 1'b0;
                            n_out_oerr     = 1'b0;
                            n_out_adrop    = 1'b0;
                            n_out_total    = r_total;
                        end
                        n_pv     = 1'b1;
                        n_pbytes = r_rd_bytes;
                        n_pdelta = diff_ext[BLOCK_BITS-1:0];
                        n_total  = r_total + 1'b1;
                        n_nrel   = r_nrel + 1'b1;
                        n_head   = head_next;
                        n_count  = r_count - 1'b1;
                        n_state  = ST_READ;
                    end
                end else begin
                    n_state = ST_FINISH;
                end
            end
            ST_FINISH: begin
                if (out_free) begin
                    n_out_valid    = 1'b1;
                    n_out_released = r_pv;
                    n_out_bytes    = r_pv ? r_pbytes : '0;
                    n_out_delta    = r_pv ? r_pdelta : '0;
                    n_out_last     = 1'b1;
                    n_out_more     = (r_count != '0);
                    n_out_oerr     = r_oerr;
                    n_out_adrop    = r_adrop;
                    n_out_total    = r_total;
                    n_state        = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_head      <= '0;
            r_tail      <= '0;
            r_count     <= '0;
            r_total     <= '0;
            r_nrel      <= '0;
            r_oerr      <= 1'b0;
            r_adrop     <= 1'b0;
            r_pv        <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_head      <= n_head;
            r_tail      <= n_tail;
            r_count     <= n_count;
            r_total     <= n_total;
            r_nrel      <= n_nrel;
            r_oerr      <= n_oerr;
            r_adrop     <= n_adrop;
            r_pv        <= n_pv;
            r_out_valid <= n_out_valid;
        end
        r_start        <= n_start;
        r_span         <= n_span;
        r_pbytes       <= n_pbytes;
        r_pdelta       <= n_pdelta;
        r_out_released <= n_out_released;
        r_out_bytes    <= n_out_bytes;
        r_out_delta    <= n_out_delta;
        r_out_last     <= n_out_last;
        r_out_more     <= n_out_more;
        r_out_oerr     <= n_out_oerr;
        r_out_adrop    <= n_out_adrop;
        r_out_total    <= n_out_total;
    end

    // event memory: one write port at the tail, one registered read at the head
    always_ff @(posedge i_clk) begin
        if (do_write) begin
            r_times[r_tail] <= i_req.event_time;
            r_bytes[r_tail] <= {i_req.event_status, i_req.event_first_data,
                                i_req.event_second_data};
        end
        r_rd_time  <= r_times[r_head];
        r_rd_bytes <= r_bytes[r_head];
    end

    assign i_req.ready           = (r_state == ST_IDLE);
    assign o_rsp.valid           = r_out_valid;
    assign o_rsp.released        = r_out_released;
    assign o_rsp.out_status      = r_out_bytes[BYTE_BITS-1 -: STATUS_BITS];
    assign o_rsp.out_first_data  = r_out_bytes[2*DATA_BITS-1 -: DATA_BITS];
    assign o_rsp.out_second_data = r_out_bytes[DATA_BITS-1:0];
    assign o_rsp.delta_frames    = r_out_delta;
    assign o_rsp.last            = r_out_last;
    assign o_rsp.more_remaining  = r_out_more;
    assign o_rsp.order_error     = r_out_oerr;
    assign o_rsp.append_dropped  = r_out_adrop;
    assign o_rsp.released_total  = r_out_total;

endmodule

`default_nettype wire

// ----- design/teq_checker.sv -----
`default_nettype none

module teq_checker
    import teq_pkg::*;
#(
    parameter int BLOCK_BITS = BLOCK_BITS_DEF
) (
    input wire logic                   i_clk,
    input wire logic                   i_rst_n,
    input wire logic                   i_req_valid,
    input wire logic                   i_req_ready,
    input wire logic                   i_rsp_valid,
    input wire logic                   i_rsp_ready,
    input wire logic                   i_released,
    input wire logic [STATUS_BITS-1:0] i_status,
    input wire logic [BLOCK_BITS-1:0]  i_delta,
    input wire logic                   i_last,
    input wire logic                   i_more,
    input wire logic                   i_oerr,
    input wire logic                   i_adrop,
    input wire logic [31:0]            i_total
);

    // a stalled result holds
    a_rsp_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && !i_rsp_ready |=> i_rsp_valid && $stable(i_total)
            && $stable(i_delta) && $stable(i_last) && $stable(i_released))
        else $error("stalled result changed");

    // a result without an event always closes its request, with empty payload
    a_empty_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && !i_released |-> i_last && i_delta == '0 && i_status == '0)
        else $error("empty result not final or not zero");

    // summary flags appear only on the final result
    a_flags_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && !i_last |-> !i_more && !i_oerr && !i_adrop)
        else $error("summary flags on a non-final result");

    // appends and block requests never flag together
    a_flag_mix: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid |-> !(i_oerr && i_adrop))
        else $error("order error and append drop together");

    // one request at a time: no new request right after one is taken
    a_one_req: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req_valid && i_req_ready |=> !i_req_ready)
        else $error("request taken while busy");

endmodule

bind timestamped_event_release_queue_top teq_checker #(
    .BLOCK_BITS (BLOCK_BITS)
) u_teq_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_req_valid (i_req.valid),
    .i_req_ready (i_req.ready),
    .i_rsp_valid (o_rsp.valid),
    .i_rsp_ready (o_rsp.ready),
    .i_released  (o_rsp.released),
    .i_status    (o_rsp.out_status),
    .i_delta     (o_rsp.delta_frames),
    .i_last      (o_rsp.last),
    .i_more      (o_rsp.more_remaining),
    .i_oerr      (o_rsp.order_error),
    .i_adrop     (o_rsp.append_dropped),
    .i_total     (o_rsp.released_total)
);

`default_nettype wire

// ----- tb/tb_timestamped_event_release_queue_top.sv -----
module tb_timestamped_event_release_queue_top;
    timeunit 1ns;
    timeprecision 1ps;

    import teq_pkg::*;

    localparam int          QDEPTH      = QUEUE_DEPTH_DEF;
    localparam int          BLOCK_BITS  = BLOCK_BITS_DEF;
    localparam logic [31:0] TIME_TOP    = 32'hFFFF_FFFF;
    localparam int          RANDOM_ITEMS = 20;
    localparam int          FILL_AT     = 6;
    localparam int          CYCLE_LIMIT = 300000;
    localparam int          SETTLE_CYCLES = 200;

    typedef struct packed {
        logic                   command;
        logic [31:0]            event_time;
        logic [STATUS_BITS-1:0] status;
        logic [DATA_BITS-1:0]   first_data;
        logic [DATA_BITS-1:0]   second_data;
        logic [31:0]            block_start;
        logic [BLOCK_BITS-1:0]  block_size;
    } event_req_t;

    typedef struct packed {
        logic                   released;
        logic [STATUS_BITS-1:0] status;
        logic [DATA_BITS-1:0]   first_data;
        logic [DATA_BITS-1:0]   second_data;
        logic [BLOCK_BITS-1:0]  delta;
        logic                   last;
        logic                   more;
        logic                   oerr;
        logic                   adrop;
        logic [31:0]            total;
    } event_rsp_t;

    typedef struct {
        event_req_t req;
        bit         typed;
        event_rsp_t want;
    } stim_row_t;

    logic i_clk = 1'b0;
    logic i_rst_n;

    teq_req_if req_bus ();
    teq_rsp_if rsp_bus ();

    timestamped_event_release_queue_top DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_bus),
        .o_rsp   (rsp_bus)
    );

    always #4 i_clk = ~i_clk;

    // shadow copy of the event queue
    logic [31:0]   shadow_time [QDEPTH];
    logic [21:0]   shadow_bytes [QDEPTH];
    int unsigned   shadow_head;
    int unsigned   shadow_tail;
    int unsigned   shadow_count;
    logic [31:0]   shadow_total;

    event_rsp_t    step_replies[$];
    event_rsp_t    due_replies[$];
    stim_row_t     directed_rows[$];

    bit            sender_idles = 1'b1;
    bit            receiver_idles = 1'b1;
    logic [31:0]   cursor;
    logic [31:0]   last_time;

    int            fail_count;
    int            cycle_count;
    int            appends_sent;
    int            blocks_sent;
    int            results_seen;
    int            released_seen;
    int            drops_seen;
    int            stale_seen;

    function automatic event_rsp_t quiet_reply(logic more, logic oerr, logic adrop,
                                               logic [31:0] total);
        event_rsp_t r;
        r = '0;
        r.last = 1'b1;
        r.more = more;
        r.oerr = oerr;
        r.adrop = adrop;
        r.total = total;
        return r;
    endfunction

    // computes the replies of one request and advances the shadow queue
    function automatic void walk_event_queue(event_req_t r);
        logic [32:0] blk_end;
        logic [31:0] t;
        logic [31:0] diff;
        logic [21:0] b;
        bit          stale;
        bit          full;
        int          n;
        event_rsp_t  res;
        step_replies.delete();
        stale = 1'b0;
        n = 0;
        if (r.command == CMD_APPEND) begin
            full = shadow_count >= QDEPTH;
            if (!full) begin
                shadow_time[shadow_tail] = r.event_time;
                shadow_bytes[shadow_tail] = {r.status, r.first_data, r.second_data};
                shadow_tail = (shadow_tail + 1) % QDEPTH;
                shadow_count++;
            end
            step_replies.push_back(quiet_reply(shadow_count != 0, 1'b0, full, shadow_total));
            return;
        end
        blk_end = {1'b0, r.block_start} + {17'd0, r.block_size};
        if (blk_end > {1'b0, TIME_TOP}) blk_end = {1'b0, TIME_TOP};
        while (shadow_count != 0 && n < MAX_RESULTS) begin
            t = shadow_time[shadow_head];
            b = shadow_bytes[shadow_head];
            if (t < r.block_start) begin
                stale = 1'b1;
            end else if ({1'b0, t} < blk_end) begin
                shadow_total++;
                diff = t - r.block_start;
                res = '0;
                res.released = 1'b1;
                res.status = b[21:14];
                res.first_data = b[13:7];
                res.second_data = b[6:0];
                res.delta = diff[BLOCK_BITS-1:0];
                res.total = shadow_total;
                step_replies.push_back(res);
                n++;
            end else begin
                break;
            end
            shadow_head = (shadow_head + 1) % QDEPTH;
            shadow_count--;
        end
        if (n == 0) begin
            step_replies.push_back(quiet_reply(shadow_count != 0, stale, 1'b0, shadow_total));
        end else begin
            step_replies[n-1].last = 1'b1;
            step_replies[n-1].more = shadow_count != 0;
            step_replies[n-1].oerr = stale;
        end
    endfunction

    function automatic stim_row_t append_row(logic [31:0] t, logic [7:0] st, logic [6:0] d1,
                                             logic [6:0] d2, logic [31:0] total);
        stim_row_t row;
        row.req = '0;
        row.req.command = CMD_APPEND;
        row.req.event_time = t;
        row.req.status = st;
        row.req.first_data = d1;
        row.req.second_data = d2;
        row.typed = 1'b1;
        row.want = quiet_reply(1'b1, 1'b0, 1'b0, total);
        return row;
    endfunction

    function automatic stim_row_t block_row(logic [31:0] start, logic [15:0] size);
        stim_row_t row;
        row.req = '0;
        row.req.command = CMD_BLOCK;
        row.req.block_start = start;
        row.req.block_size = size;
        row.typed = 1'b0;
        row.want = '0;
        return row;
    endfunction

    function automatic stim_row_t block_quiet_row(logic [31:0] start, logic [15:0] size,
                                                  logic more, logic oerr, logic [31:0] total);
        stim_row_t row;
        row = block_row(start, size);
        row.typed = 1'b1;
        row.want = quiet_reply(more, oerr, 1'b0, total);
        return row;
    endfunction

    function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, want, got);
            fail_count++;
        end
    endfunction

    function automatic logic [31:0] next_event_time();
        logic [32:0] t;
        t = {1'b0, (last_time > cursor) ? last_time : cursor} + $urandom_range(0, 60);
        if (t > 33'h0_FFFF_FFFE) t = 33'h0_FFFF_FFFE;
        last_time = t[31:0];
        return t[31:0];
    endfunction

    function automatic void advance_cursor(logic [31:0] start, logic [15:0] size);
        logic [32:0] c;
        c = {1'b0, start} + {17'd0, size};
        cursor = (c > {1'b0, TIME_TOP}) ? TIME_TOP : c[31:0];
    endfunction

    function automatic logic [15:0] pick_block_size();
        int sel;
        sel = $urandom_range(0, 19);
        if (sel == 0) return 16'd0;
        if (sel == 1) return 16'hFFFF;
        if (sel == 2) return 16'($urandom);
        return 16'($urandom_range(1, 150));
    endfunction

    task automatic send_request(input event_req_t r, input bit typed, input event_rsp_t want);
        int gap;
        gap = (sender_idles && $urandom_range(0, 3) == 0) ? $urandom_range(1, 6) : 0;
        @(negedge i_clk);
        if (gap != 0) begin
            req_bus.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        req_bus.command <= r.command;
        req_bus.event_time <= r.event_time;
        req_bus.event_status <= r.status;
        req_bus.event_first_data <= r.first_data;
        req_bus.event_second_data <= r.second_data;
        req_bus.block_start <= r.block_start;
        req_bus.block_size <= r.block_size;
        req_bus.valid <= 1'b1;
        @(posedge i_clk);
        while (req_bus.ready !== 1'b1) @(posedge i_clk);
        walk_event_queue(r);
        if (typed) begin
            due_replies.push_back(want);
        end else begin
            foreach (step_replies[j]) due_replies.push_back(step_replies[j]);
        end
        if (r.command == CMD_APPEND) appends_sent++;
        else blocks_sent++;
    endtask

    task automatic append_event(input logic [31:0] t);
        event_req_t r;
        r.command = CMD_APPEND;
        r.event_time = t;
        r.status = STATUS_BITS'($urandom);
        r.first_data = DATA_BITS'($urandom);
        r.second_data = DATA_BITS'($urandom);
        r.block_start = $urandom;
        r.block_size = BLOCK_BITS'($urandom);
        send_request(r, 1'b0, '0);
    endtask

    task automatic request_block(input logic [31:0] start, input logic [15:0] size);
        event_req_t r;
        r.command = CMD_BLOCK;
        r.event_time = $urandom;
        r.status = STATUS_BITS'($urandom);
        r.first_data = DATA_BITS'($urandom);
        r.second_data = DATA_BITS'($urandom);
        r.block_start = start;
        r.block_size = size;
        send_request(r, 1'b0, '0);
        advance_cursor(start, size);
    endtask

    task automatic wait_drained();
        @(negedge i_clk);
        req_bus.valid <= 1'b0;
        while (due_replies.size() != 0) @(posedge i_clk);
    endtask

    // releases or drops everything below the top timestamp
    task automatic flush_queue();
        request_block(TIME_TOP - 32'd1, 16'd1);
    endtask

    task automatic rebase_cursor();
        wait_drained();
        flush_queue();
        if ($urandom_range(0, 2) == 0) cursor = TIME_TOP - $urandom_range(0, 70000);
        else cursor = $urandom;
        last_time = cursor;
    endtask

    // fills the queue past its depth, then releases all of it in one block
    task automatic fill_queue();
        logic [31:0] start;
        wait_drained();
        flush_queue();
        cursor = $urandom_range(0, 32'h7FFF_FFFF);
        last_time = cursor;
        start = cursor;
        while (shadow_count < QDEPTH) append_event(next_event_time());
        repeat (2) append_event(next_event_time());
        request_block(start, 16'hFFFF);
    endtask

    initial begin
        int stall;
        stall = 0;
        rsp_bus.ready = 1'b0;
        wait (i_rst_n === 1'b1);
        forever begin
            @(negedge i_clk);
            if (stall > 0) stall--;
            else if (receiver_idles && $urandom_range(0, 7) == 0) stall = $urandom_range(1, 6);
            rsp_bus.ready <= (stall == 0);
        end
    end

    always @(posedge i_clk) begin
        event_rsp_t got;
        event_rsp_t want;
        if (i_rst_n === 1'b1 && rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1) begin
            got.released = rsp_bus.released;
            got.status = rsp_bus.out_status;
            got.first_data = rsp_bus.out_first_data;
            got.second_data = rsp_bus.out_second_data;
            got.delta = rsp_bus.delta_frames;
            got.last = rsp_bus.last;
            got.more = rsp_bus.more_remaining;
            got.oerr = rsp_bus.order_error;
            got.adrop = rsp_bus.append_dropped;
            got.total = rsp_bus.released_total;
            results_seen++;
            if (got.released === 1'b1) released_seen++;
            if (got.adrop === 1'b1) drops_seen++;
            if (got.oerr === 1'b1) stale_seen++;
            if (due_replies.size() == 0) begin
                $display("%0t: result with nothing expected, actual %p", $time, got);
                fail_count++;
            end else begin
                want = due_replies.pop_front();
                check_field("released", 32'(want.released), 32'(got.released));
                check_field("out_status", 32'(want.status), 32'(got.status));
                check_field("out_first_data", 32'(want.first_data), 32'(got.first_data));
                check_field("out_second_data", 32'(want.second_data), 32'(got.second_data));
                check_field("delta_frames", 32'(want.delta), 32'(got.delta));
                check_field("last", 32'(want.last), 32'(got.last));
                check_field("more_remaining", 32'(want.more), 32'(got.more));
                check_field("order_error", 32'(want.oerr), 32'(got.oerr));
                check_field("append_dropped", 32'(want.adrop), 32'(got.adrop));
                check_field("released_total", want.total, got.total);
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("%0t: timeout, %0d results still due", $time, due_replies.size());
            $display("== FAIL ==");
            $finish;
        end
    end

    initial begin
        int          pick;
        logic [31:0] t;
        logic [31:0] start;
        logic [15:0] size;

        i_rst_n = 1'b0;
        req_bus.valid = 1'b0;
        req_bus.command = CMD_APPEND;
        req_bus.event_time = '0;
        req_bus.event_status = '0;
        req_bus.event_first_data = '0;
        req_bus.event_second_data = '0;
        req_bus.block_start = '0;
        req_bus.block_size = '0;
        shadow_head = 0;
        shadow_tail = 0;
        shadow_count = 0;
        shadow_total = '0;
        foreach (shadow_time[i]) begin
            shadow_time[i] = '0;
            shadow_bytes[i] = '0;
        end

        // empty queue, extremes, stale drops, zero size, saturated block end
        directed_rows.push_back(block_quiet_row(32'd0, 16'd0, 1'b0, 1'b0, 32'd0));
        directed_rows.push_back(block_quiet_row(TIME_TOP, 16'hFFFF, 1'b0, 1'b0, 32'd0));
        directed_rows.push_back(append_row(32'd100, 8'h90, 7'h3C, 7'h7F, 32'd0));
        directed_rows.push_back(append_row(32'd0, 8'h00, 7'h00, 7'h00, 32'd0));
        directed_rows.push_back(append_row(32'd150, 8'hFF, 7'h7F, 7'h7F, 32'd0));
        directed_rows.push_back(block_row(32'd50, 16'd100));
        directed_rows.push_back(block_quiet_row(32'd150, 16'd0, 1'b1, 1'b0, 32'd1));
        directed_rows.push_back(block_quiet_row(32'd200, 16'd10, 1'b0, 1'b1, 32'd1));
        directed_rows.push_back(append_row(32'hFFFF_FFFE, 8'h80, 7'h40, 7'h01, 32'd1));
        directed_rows.push_back(block_row(32'hFFFF_FF00, 16'hFFFF));
        directed_rows.push_back(append_row(32'd1000, 8'hB0, 7'h07, 7'h40, 32'd2));
        directed_rows.push_back(append_row(32'd1000, 8'hC5, 7'h11, 7'h00, 32'd2));
        directed_rows.push_back(append_row(32'd1001, 8'hE0, 7'h00, 7'h7F, 32'd2));
        directed_rows.push_back(block_row(32'd1000, 16'd1));
        directed_rows.push_back(block_row(32'd1001, 16'hFFFF));
        directed_rows.push_back(append_row(32'd2000, 8'h91, 7'h55, 7'h2A, 32'd5));
        directed_rows.push_back(append_row(32'd1500, 8'h81, 7'h2A, 7'h55, 32'd5));
        directed_rows.push_back(block_row(32'd1800, 16'd500));
        directed_rows.push_back(append_row(32'h0001_FFFE, 8'hA0, 7'h7F, 7'h7F, 32'd6));
        directed_rows.push_back(block_row(32'h0001_0000, 16'hFFFF));
        directed_rows.push_back(append_row(32'h8000_0000, 8'h00, 7'h7F, 7'h00, 32'd7));
        directed_rows.push_back(block_row(32'h7FFF_FFFF, 16'd2));

        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed_rows[i])
            send_request(directed_rows[i].req, directed_rows[i].typed, directed_rows[i].want);

        cursor = $urandom_range(0, 1000);
        last_time = cursor;
        for (int k = 0; k < RANDOM_ITEMS; k++) begin
            if (k % 12 == 0) begin
                sender_idles = $urandom_range(0, 3) != 0;
                receiver_idles = $urandom_range(0, 3) != 0;
            end
            if (k >= RANDOM_ITEMS - 6) begin
                sender_idles = 1'b0;
                receiver_idles = 1'b0;
            end
            if (k == FILL_AT) fill_queue();
            pick = $urandom_range(0, 99);
            if (pick < 48) begin
                append_event(next_event_time());
            end else if (pick < 78) begin
                size = pick_block_size();
                request_block(cursor, size);
            end else if (pick < 86) begin
                // arrives after its block has passed
                t = (cursor > 32'd64) ? cursor - $urandom_range(1, 64) : 32'd0;
                append_event(t);
            end else if (pick < 91) begin
                t = $urandom;
                // an event at the top timestamp would sit at the head for good
                if (t == TIME_TOP) t = TIME_TOP - 32'd1;
                append_event(t);
            end else if (pick < 96) begin
                start = $urandom;
                size = 16'($urandom);
                request_block(start, size);
            end else begin
                rebase_cursor();
            end
            if (cursor >= 32'hFFFF_FF00) rebase_cursor();
        end

        // a top timestamp event is never inside a saturated block
        flush_queue();
        append_event(TIME_TOP);
        request_block(32'hFFFF_0000, 16'hFFFF);

        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        $display("run covered %0d appends and %0d block requests, %0d results checked",
                 appends_sent, blocks_sent, results_seen);
        $display("%0d events released, %0d appends refused when full, %0d stale drops flagged",
                 released_seen, drops_seen, stale_seen);
        if (fail_count == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

// ----- sim.f -----
design/teq_pkg.sv
design/teq_req_if.sv
design/teq_rsp_if.sv
design/timestamped_event_release_queue_top.sv
design/teq_checker.sv
tb/tb_timestamped_event_release_queue_top.sv
